// File: design/cie_pkg.sv
// ----------------------------------------------------------------------------
// cie_pkg: shared definitions for the collision integral evaluator
// Field widths, fixed-point formats, segment and status codes and the
// Q32 fit coefficients worked out at elaboration from their decimal forms.
// ----------------------------------------------------------------------------
`default_nettype none

package cie_pkg;

	// word fields
	localparam int TEMP_W   = 24;
	localparam int EPS_W    = 17;
	localparam int OMEGA_W  = 22;
	localparam int STATUS_W = 2;

	// reduced temperature, unsigned with 16 fraction bits
	localparam int T_W    = 23;
	localparam int T_FRAC = 16;

	// divider: numerator, divisor and quotient widths
	localparam int NUM_W = 44;
	localparam int DVS_W = EPS_W + 1;
	localparam int QUO_W = T_W;

	// polynomial accumulator (signed Q32), its magnitude and products by t
	localparam int ACC_W = 41;
	localparam int MAG_W = ACC_W - 1;
	localparam int PRD_W = MAG_W + T_W;

	// factors of the omega(2,2) product, Q26 saturated below 2^31
	localparam int Q26_W = 31;

	// t = temperature * 409600 / eps, formed as (2*temp*409600 + eps) / (2*eps)
	localparam int unsigned TSTAR_SCALE = 819200;

	localparam logic [T_W-1:0] TSTAR_CLAMP = T_W'(6553600);
	localparam logic [T_W-1:0] SEG_ONE     = T_W'(327680);
	localparam logic [T_W-1:0] SEG_TWO     = T_W'(655360);

	localparam logic [OMEGA_W-1:0] OMEGA_MAX = '1;

	// fit segments and their scale shifts
	localparam logic [1:0] SEG_LOW  = 2'd0;
	localparam logic [1:0] SEG_MID  = 2'd1;
	localparam logic [1:0] SEG_HIGH = 2'd2;

	localparam int SB_LOW  = 3;
	localparam int SB_MID  = 4;
	localparam int SB_HIGH = 7;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ZERO_EPS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BOUNDS   = 2'd2;

	// order of the omega(1,1) fit; the a-star fit is padded to the same order
	localparam int HRN_ORD = 4;

	// coefficient mant * 10^-dexp scaled by 2^(k*sb), rounded to Q32
	function automatic logic signed [ACC_W-1:0] coef_q32(input int mant, input int dexp,
			input int k, input int sb);
		logic [63:0] den;
		logic [63:0] mag;
		logic [63:0] q;
		logic [63:0] r;
		logic        neg;
		den = 64'd1;
		q   = '0;
		r   = '0;
		neg = (mant < 0);
		mag = neg ? 64'(-mant) : 64'(mant);
		for (int i = 0; i < dexp; i++) begin
			den = den * 64'd10;
		end
		mag = mag << (k * sb);
		// integer part, one bit a step
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], mag[i]};
			q = {q[62:0], 1'b0};
			if (r >= den) begin
				r    = r - den;
				q[0] = 1'b1;
			end
		end
		// 32 fraction bits and one for rounding
		for (int i = 0; i < 33; i++) begin
			r = {r[62:0], 1'b0};
			q = {q[62:0], 1'b0};
			if (r >= den) begin
				r    = r - den;
				q[0] = 1'b1;
			end
		end
		q = (q + 64'd1) >> 1;
		return ACC_W'(neg ? -q : q);
	endfunction

	// omega(1,1) quartic, lowest order first, one row per segment
	localparam logic signed [ACC_W-1:0] OM_COEF [4][5] = '{
		'{coef_q32(23527333, 7, 0, SB_LOW),  coef_q32(-13589968, 7, 1, SB_LOW),
		  coef_q32(52202460, 8, 2, SB_LOW),  coef_q32(-94262883, 9, 3, SB_LOW),
		  coef_q32(64354629, 10, 4, SB_LOW)},
		'{coef_q32(12660308, 7, 0, SB_MID),  coef_q32(-16441443, 8, 1, SB_MID),
		  coef_q32(22945928, 9, 2, SB_MID),  coef_q32(-16324168, 10, 3, SB_MID),
		  coef_q32(45833672, 12, 4, SB_MID)},
		'{coef_q32(85263337, 8, 0, SB_HIGH), coef_q32(-13552911, 9, 1, SB_HIGH),
		  coef_q32(26162080, 11, 2, SB_HIGH), coef_q32(-24647654, 13, 3, SB_HIGH),
		  coef_q32(86538568, 16, 4, SB_HIGH)},
		'{default: '0}
	};

	// a-star quadratic, padded with zero terms up to the quartic order
	localparam logic signed [ACC_W-1:0] AST_COEF [4][5] = '{
		'{coef_q32(11077725, 7, 0, SB_LOW),  coef_q32(-94802344, 10, 1, SB_LOW),
		  coef_q32(16918277, 10, 2, SB_LOW), '0, '0},
		'{coef_q32(10871429, 7, 0, SB_MID),  coef_q32(31964282, 10, 1, SB_MID),
		  coef_q32(-89285689, 12, 2, SB_MID), '0, '0},
		'{coef_q32(11059000, 7, 0, SB_HIGH), coef_q32(65136364, 11, 1, SB_HIGH),
		  coef_q32(-34090910, 13, 2, SB_HIGH), '0, '0},
		'{default: '0}
	};

endpackage

`default_nettype wire

// File: design/cie_if.sv
// ----------------------------------------------------------------------------
// cie_if: word channels of the collision integral evaluator
// Valid/ready channels for the input word (temperature, well depth) and the
// result word (both collision integrals and status).
// ----------------------------------------------------------------------------
`default_nettype none

interface cie_in_if;
	import cie_pkg::*;

	logic                valid;
	logic                ready;
	logic [TEMP_W-1:0]   temperature;
	logic [EPS_W-1:0]    well_depth;

	modport source (output valid, output temperature, output well_depth, input ready);
	modport sink   (input valid, input temperature, input well_depth, output ready);
endinterface

interface cie_out_if;
	import cie_pkg::*;

	logic                valid;
	logic                ready;
	logic [OMEGA_W-1:0]  omega_one_one;
	logic [OMEGA_W-1:0]  omega_two_two;
	logic [STATUS_W-1:0] status;

	modport source (output valid, output omega_one_one, output omega_two_two,
		output status, input ready);
	modport sink   (input valid, input omega_one_one, input omega_two_two,
		input status, output ready);
endinterface

`default_nettype wire

// File: design/collision_integral_evaluator_core.sv
// ----------------------------------------------------------------------------
// collision_integral_evaluator_core: Lennard-Jones omega(1,1)/omega(2,2) fit
// Pipelined fixed-point evaluation of both collision integrals per word.
// ----------------------------------------------------------------------------
// Usage
//   sample carries temperature (1/16 K) and well_depth (0.01 K); result
//   carries omega_one_one and omega_two_two (unsigned Q2.20) and status.
//   Both are valid/ready channels; a word moves when valid and ready are high.
//   The datapath is a 37 stage pipeline: two stages set up the division, 23
//   stages produce one quotient bit each, one stage clamps t and picks the
//   segment, four Horner steps take two stages each (multiply, round and add),
//   and three stages convert and form the omega(2,2) product.
//   One word can enter every cycle while the result side takes words, so
//   throughput is one word per cycle.
//   Each stage holds only while the stage after it is full and stalled, so
//   empty stages still fill while result is held back: a stall loses and
//   repeats nothing, and sample.ready stays high while bubbles remain.
//   Reset clears all valid bits at once; no word is in flight afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module collision_integral_evaluator_core (
	input  logic      clk,
	input  logic      arst_n,
	cie_in_if.sink    sample,
	cie_out_if.source result
);
	import cie_pkg::*;

	// stage map: division, clamp, horner pairs, conversion, product, output
	localparam int DIV_N   = QUO_W + 2;
	localparam int ST_T    = DIV_N;
	localparam int ST_CONV = ST_T + 2 * HRN_ORD + 1;
	localparam int ST_MUL  = ST_CONV + 1;
	localparam int ST_OUT  = ST_CONV + 2;
	localparam int NS      = ST_OUT + 1;

	localparam int O11_SH = 12;
	localparam int Q26_SH = 6;
	localparam int O22_SH = 32;

	typedef struct packed {
		logic [NUM_W-1:0] rem;
		logic [DVS_W-1:0] dvs;
		logic [QUO_W-1:0] quo;
		logic             ovf;
		logic             zero;
	} div_t;

	typedef struct packed {
		logic [T_W-1:0]          t;
		logic [1:0]              seg;
		logic signed [ACC_W-1:0] om;
		logic signed [ACC_W-1:0] ast;
		logic                    zero;
	} acc_t;

	typedef struct packed {
		logic [T_W-1:0]   t;
		logic [1:0]       seg;
		logic [PRD_W-1:0] om_p;
		logic [PRD_W-1:0] ast_p;
		logic             om_neg;
		logic             ast_neg;
		logic             zero;
	} prd_t;

	typedef struct packed {
		logic [OMEGA_W-1:0]  o11;
		logic [Q26_W-1:0]    om26;
		logic [Q26_W-1:0]    ast26;
		logic [STATUS_W-1:0] st;
		logic                keep;
	} cnv_t;

	typedef struct packed {
		logic [OMEGA_W-1:0]   o11;
		logic [2*Q26_W-1:0]   p;
		logic [STATUS_W-1:0]  st;
		logic                 keep;
	} pmul_t;

	typedef struct packed {
		logic [OMEGA_W-1:0]  o11;
		logic [OMEGA_W-1:0]  o22;
		logic [STATUS_W-1:0] st;
	} res_t;

	// magnitude times t, shifted down by 16 plus the segment shift, half up
	function automatic logic [MAG_W-1:0] rnd_shift(input logic [PRD_W-1:0] p,
			input logic [1:0] seg);
		logic [PRD_W:0] s;
		case (seg)
			SEG_LOW: begin
				s = {1'b0, p} + ((PRD_W+1)'(1) << (T_FRAC + SB_LOW - 1));
				rnd_shift = MAG_W'(s >> (T_FRAC + SB_LOW));
			end
			SEG_MID: begin
				s = {1'b0, p} + ((PRD_W+1)'(1) << (T_FRAC + SB_MID - 1));
				rnd_shift = MAG_W'(s >> (T_FRAC + SB_MID));
			end
			SEG_HIGH: begin
				s = {1'b0, p} + ((PRD_W+1)'(1) << (T_FRAC + SB_HIGH - 1));
				rnd_shift = MAG_W'(s >> (T_FRAC + SB_HIGH));
			end
			default: begin
				s = '0;
				rnd_shift = '0;
			end
		endcase
	endfunction

	// positive Q32 to Q26, rounded half up, saturated below 2^31
	function automatic logic [Q26_W-1:0] q26_sat(input logic [MAG_W-1:0] v);
		logic [MAG_W:0] s;
		s = {1'b0, v} + ((MAG_W+1)'(1) << (Q26_SH - 1));
		if (s[MAG_W:Q26_SH] > (MAG_W+1-Q26_SH)'({Q26_W{1'b1}})) begin
			q26_sat = '1;
		end else begin
			q26_sat = s[Q26_W+Q26_SH-1:Q26_SH];
		end
	endfunction

	logic [NS-1:0] vld_s;
	logic [NS-1:0] vld_in;
	logic [NS:0]   go;

	div_t  div_s [DIV_N];          // stages 1 to 25
	acc_t  acc_s [HRN_ORD+1];      // clamp stage, then after each horner step
	prd_t  prd_s [1:HRN_ORD];      // product stage of each horner step
	cnv_t  cnv_s35;
	pmul_t mul_s36;
	res_t  res_s37;

	// stage advance: a stage loads when empty or when its successor moves
	always_comb begin
		go[NS] = result.ready;
		for (int i = NS - 1; i >= 0; i--) begin
			go[i] = !vld_s[i] || go[i+1];
		end
	end

	assign vld_in       = {vld_s[NS-2:0], sample.valid};
	assign sample.ready = go[0];

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int i = 0; i < NS; i++) begin
				if (go[i]) begin
					vld_s[i] <= vld_in[i];
				end
			end
		end
	end

	// numerator and divisor of the reduced temperature
	always_ff @(posedge clk) begin
		if (go[0]) begin
			div_s[0] <= '{
				rem:  NUM_W'(sample.temperature) * NUM_W'(TSTAR_SCALE)
					+ NUM_W'(sample.well_depth),
				dvs:  {sample.well_depth, 1'b0},
				quo:  '0,
				ovf:  1'b0,
				zero: (sample.well_depth == '0)
			};
		end
	end

	// quotient beyond the quotient width means the clamp applies
	always_ff @(posedge clk) begin
		if (go[1]) begin
			div_s[1] <= '{
				rem:  div_s[0].rem,
				dvs:  div_s[0].dvs,
				quo:  div_s[0].quo,
				ovf:  (div_s[0].rem >= NUM_W'({div_s[0].dvs, QUO_W'(0)})),
				zero: div_s[0].zero
			};
		end
	end

	// restoring division, one quotient bit per stage, msb first
	for (genvar k = 0; k < QUO_W; k++) begin : g_div
		localparam int B = QUO_W - 1 - k;
		logic [NUM_W:0] trial;
		div_t           div_nxt;

		assign trial = {1'b0, div_s[k+1].rem} - ((NUM_W+1)'(div_s[k+1].dvs) << B);

		always_comb begin
			div_nxt = div_s[k+1];
			if (!trial[NUM_W]) begin
				div_nxt.rem    = trial[NUM_W-1:0];
				div_nxt.quo[B] = 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (go[k+2]) begin
				div_s[k+2] <= div_nxt;
			end
		end
	end

	// clamp, segment choice and leading coefficients
	logic [T_W-1:0] t_nxt;
	logic [1:0]     seg_nxt;

	always_comb begin
		if (div_s[DIV_N-1].ovf || (div_s[DIV_N-1].quo > TSTAR_CLAMP)) begin
			t_nxt = TSTAR_CLAMP;
		end else begin
			t_nxt = div_s[DIV_N-1].quo;
		end
		if (t_nxt < SEG_ONE) begin
			seg_nxt = SEG_LOW;
		end else if (t_nxt < SEG_TWO) begin
			seg_nxt = SEG_MID;
		end else begin
			seg_nxt = SEG_HIGH;
		end
	end

	always_ff @(posedge clk) begin
		if (go[ST_T]) begin
			acc_s[0] <= '{
				t:    t_nxt,
				seg:  seg_nxt,
				om:   OM_COEF[seg_nxt][HRN_ORD],
				ast:  AST_COEF[seg_nxt][HRN_ORD],
				zero: div_s[DIV_N-1].zero
			};
		end
	end

	// horner steps: magnitude product, then round, restore sign, add coefficient
	for (genvar j = 1; j <= HRN_ORD; j++) begin : g_hrn
		localparam int PM = ST_T + 2 * j - 1;
		localparam int AD = ST_T + 2 * j;
		localparam int CK = HRN_ORD - j;

		logic [MAG_W-1:0]        om_mag;
		logic [MAG_W-1:0]        ast_mag;
		logic [PRD_W-1:0]        om_prod;
		logic [PRD_W-1:0]        ast_prod;
		logic [MAG_W-1:0]        om_r;
		logic [MAG_W-1:0]        ast_r;
		logic signed [ACC_W-1:0] om_rnd;
		logic signed [ACC_W-1:0] ast_rnd;

		assign om_mag   = acc_s[j-1].om[ACC_W-1]  ? MAG_W'(-acc_s[j-1].om)
			: MAG_W'(acc_s[j-1].om);
		assign ast_mag  = acc_s[j-1].ast[ACC_W-1] ? MAG_W'(-acc_s[j-1].ast)
			: MAG_W'(acc_s[j-1].ast);
		assign om_prod  = om_mag * acc_s[j-1].t;
		assign ast_prod = ast_mag * acc_s[j-1].t;

		always_ff @(posedge clk) begin
			if (go[PM]) begin
				prd_s[j] <= '{
					t:       acc_s[j-1].t,
					seg:     acc_s[j-1].seg,
					om_p:    om_prod,
					ast_p:   ast_prod,
					om_neg:  acc_s[j-1].om[ACC_W-1],
					ast_neg: acc_s[j-1].ast[ACC_W-1],
					zero:    acc_s[j-1].zero
				};
			end
		end

		// rounding is half away from zero, done on the magnitude
		assign om_r    = rnd_shift(prd_s[j].om_p, prd_s[j].seg);
		assign ast_r   = rnd_shift(prd_s[j].ast_p, prd_s[j].seg);
		assign om_rnd  = prd_s[j].om_neg  ? -$signed({1'b0, om_r})  : $signed({1'b0, om_r});
		assign ast_rnd = prd_s[j].ast_neg ? -$signed({1'b0, ast_r}) : $signed({1'b0, ast_r});

		always_ff @(posedge clk) begin
			if (go[AD]) begin
				acc_s[j] <= '{
					t:    prd_s[j].t,
					seg:  prd_s[j].seg,
					om:   om_rnd + OM_COEF[prd_s[j].seg][CK],
					ast:  ast_rnd + AST_COEF[prd_s[j].seg][CK],
					zero: prd_s[j].zero
				};
			end
		end
	end

	// output conversion and status
	logic                    om_pos;
	logic [MAG_W:0]          o11_sum;
	logic [MAG_W-O11_SH:0]   o11_full;
	logic [OMEGA_W-1:0]      o11_sat;
	cnv_t                    cnv_nxt;

	always_comb begin
		om_pos   = !acc_s[HRN_ORD].om[ACC_W-1] && (acc_s[HRN_ORD].om != '0);
		o11_sum  = {1'b0, acc_s[HRN_ORD].om[MAG_W-1:0]}
			+ ((MAG_W+1)'(1) << (O11_SH - 1));
		o11_full = o11_sum[MAG_W:O11_SH];
		if (o11_full > (MAG_W+1-O11_SH)'(OMEGA_MAX)) begin
			o11_sat = OMEGA_MAX;
		end else begin
			o11_sat = o11_full[OMEGA_W-1:0];
		end
		cnv_nxt.om26  = q26_sat(acc_s[HRN_ORD].om[MAG_W-1:0]);
		cnv_nxt.ast26 = q26_sat(acc_s[HRN_ORD].ast[MAG_W-1:0]);
		if (acc_s[HRN_ORD].zero) begin
			cnv_nxt.st  = ST_ZERO_EPS;
			cnv_nxt.o11 = '0;
		end else if (!om_pos) begin
			cnv_nxt.st  = ST_BOUNDS;
			cnv_nxt.o11 = '0;
		end else if (acc_s[HRN_ORD].ast[ACC_W-1]) begin
			cnv_nxt.st  = ST_BOUNDS;
			cnv_nxt.o11 = o11_sat;
		end else begin
			cnv_nxt.st  = ST_OK;
			cnv_nxt.o11 = o11_sat;
		end
		cnv_nxt.keep = (cnv_nxt.st == ST_OK);
	end

	always_ff @(posedge clk) begin
		if (go[ST_CONV]) begin
			cnv_s35 <= cnv_nxt;
		end
	end

	// omega(2,2) product of the two Q26 factors
	logic [2*Q26_W-1:0] p_nxt;

	assign p_nxt = cnv_s35.om26 * cnv_s35.ast26;

	always_ff @(posedge clk) begin
		if (go[ST_MUL]) begin
			mul_s36 <= '{o11: cnv_s35.o11, p: p_nxt, st: cnv_s35.st, keep: cnv_s35.keep};
		end
	end

	// round the product to Q20 and saturate, or give zero unless status is OK
	logic [2*Q26_W:0]          o22_sum;
	logic [2*Q26_W-O22_SH:0]   o22_full;
	logic [OMEGA_W-1:0]        o22_nxt;

	always_comb begin
		o22_sum  = {1'b0, mul_s36.p} + ((2*Q26_W+1)'(1) << (O22_SH - 1));
		o22_full = o22_sum[2*Q26_W:O22_SH];
		if (!mul_s36.keep) begin
			o22_nxt = '0;
		end else if (o22_full > (2*Q26_W+1-O22_SH)'(OMEGA_MAX)) begin
			o22_nxt = OMEGA_MAX;
		end else begin
			o22_nxt = o22_full[OMEGA_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (go[ST_OUT]) begin
			res_s37 <= '{o11: mul_s36.o11, o22: o22_nxt, st: mul_s36.st};
		end
	end

	assign result.valid         = vld_s[NS-1];
	assign result.omega_one_one = res_s37.o11;
	assign result.omega_two_two = res_s37.o22;
	assign result.status        = res_s37.st;

endmodule

`default_nettype wire

// File: design/cie_checker.sv
// ----------------------------------------------------------------------------
// cie_checker: port-level checks for the collision integral evaluator
// Watches the word channels and checks result holding and status coding.
// ----------------------------------------------------------------------------
`default_nettype none

module cie_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_ready,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [cie_pkg::OMEGA_W-1:0]   o11,
	input  logic [cie_pkg::OMEGA_W-1:0]   o22,
	input  logic [cie_pkg::STATUS_W-1:0]  status
);
	import cie_pkg::*;

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(o11) && $stable(o22)
			&& $stable(status))
		else $error("result word changed while stalled");

	// an empty output stage means the pipeline can take a word
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with output stage empty");

	// zero well depth gives zero integrals
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_ZERO_EPS |-> o11 == '0 && o22 == '0)
		else $error("nonzero integral with zero well depth");

	// a fit out of bounds never yields omega(2,2)
	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_BOUNDS |-> o22 == '0)
		else $error("omega(2,2) given with fit out of bounds");

	// status carries a defined code
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == ST_OK || status == ST_ZERO_EPS || status == ST_BOUNDS)
		else $error("undefined status code");

endmodule

bind collision_integral_evaluator_core cie_checker u_cie_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (sample.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.o11       (result.omega_one_one),
	.o22       (result.omega_two_two),
	.status    (result.status)
);

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 100ps

// ----------------------------------------------------------------------------
// tb_top: testbench for collision_integral_evaluator_core
// Drives temperature and well depth words through the valid/ready input
// channel and checks every result word against a fixed-point model of the
// omega(1,1) / omega(2,2) fits. A directed table comes first, then random
// words with random idling on both channels, a run with no idling, a long
// hold-off on the result side that fills the pipeline, and pauses until
// every expected word has come.
// ----------------------------------------------------------------------------
module tb_top;
	import cie_pkg::*;

	localparam int WORD_GAP_MAX   = 10;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 60;
	localparam int LONG_HOLD      = 150;
	localparam int REPORT_CAP     = 200;

	// reduced temperature limits, Q16
	localparam longint unsigned TSTAR_MAX_Q16 = 64'd6553600;
	localparam longint unsigned SEG_MID_Q16   = 64'd327680;
	localparam longint unsigned SEG_HIGH_Q16  = 64'd655360;
	localparam longint unsigned OMEGA_TOP     = 64'd4194303;
	localparam longint unsigned Q26_TOP       = 64'h7FFF_FFFF;

	typedef struct packed {
		logic [OMEGA_W-1:0]  omega_one_one;
		logic [OMEGA_W-1:0]  omega_two_two;
		logic [STATUS_W-1:0] status;
	} omega_word_t;

	typedef struct packed {
		logic [TEMP_W-1:0] temperature;
		logic [EPS_W-1:0]  well_depth;
		logic              typed;
		omega_word_t       want;
	} probe_row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always #2 clk = ~clk;

	cie_in_if  sample_if ();
	cie_out_if result_if ();

	collision_integral_evaluator_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_if),
		.result (result_if)
	);

	omega_word_t omega_expected [$];
	longint      om_coef [3][5];
	longint      astar_coef [3][3];
	int          mismatch_count = 0;
	bit          idle_on        = 1'b1;
	int          result_hold    = 0;

	// scale shift of each fit segment
	function automatic int fit_shift(input logic [1:0] seg);
		case (seg)
			SEG_LOW: return 3;
			SEG_MID: return 4;
			default: return 7;
		endcase
	endfunction

	// mant * 10^-dexp * 2^(k*shift) as signed Q32, rounded to nearest
	function automatic longint scaled_coef(input longint mant, input int dexp, input int k,
			input logic [1:0] seg);
		logic [127:0] num;
		logic [127:0] den;
		logic [127:0] quo;
		den = 128'd1;
		for (int i = 0; i < dexp; i++) den = den * 128'd10;
		num = 128'(mant < 0 ? -mant : mant) << (k * fit_shift(seg) + 33);
		quo = (num / den + 128'd1) >> 1;
		return (mant < 0) ? -longint'(quo[63:0]) : longint'(quo[63:0]);
	endfunction

	// acc * t >> sh, rounded half away from zero
	function automatic longint round_scale(input longint acc, input longint unsigned tq,
			input int sh);
		longint unsigned mag;
		longint unsigned rnd;
		mag = (acc < 0) ? -acc : acc;
		rnd = (mag * tq + (64'd1 << (sh - 1))) >> sh;
		return (acc < 0) ? -longint'(rnd) : longint'(rnd);
	endfunction

	// q32 to q26, rounded half up and held below 2^31
	function automatic longint unsigned to_q26_sat(input longint v);
		longint unsigned r;
		r = ($unsigned(v) + 64'd32) >> 6;
		return (r > Q26_TOP) ? Q26_TOP : r;
	endfunction

	function automatic omega_word_t predict_omega(input logic [TEMP_W-1:0] temp,
			input logic [EPS_W-1:0] eps);
		omega_word_t     w;
		longint unsigned tq;
		longint unsigned prod;
		longint unsigned one_one;
		longint unsigned two_two;
		longint          om;
		longint          astar;
		logic [1:0]      seg;
		int              sh;
		w = '0;
		if (eps == '0) begin
			w.status = ST_ZERO_EPS;
			return w;
		end
		// reduced temperature, rounded half up, clamped at 100
		tq = (64'(temp) * 64'd819200 + 64'(eps)) / (64'(eps) * 64'd2);
		if (tq > TSTAR_MAX_Q16) tq = TSTAR_MAX_Q16;
		if (tq < SEG_MID_Q16) begin
			seg = SEG_LOW;
		end else if (tq < SEG_HIGH_Q16) begin
			seg = SEG_MID;
		end else begin
			seg = SEG_HIGH;
		end
		sh = 16 + fit_shift(seg);
		// horner over the quartic and the quadratic
		om = om_coef[seg][4];
		for (int k = 3; k >= 0; k--) om = round_scale(om, tq, sh) + om_coef[seg][k];
		astar = astar_coef[seg][2];
		for (int k = 1; k >= 0; k--) astar = round_scale(astar, tq, sh) + astar_coef[seg][k];
		if (om <= 0) begin
			w.status = ST_BOUNDS;
			return w;
		end
		one_one = ($unsigned(om) + 64'd2048) >> 12;
		w.omega_one_one = OMEGA_W'((one_one > OMEGA_TOP) ? OMEGA_TOP : one_one);
		if (astar < 0) begin
			w.status = ST_BOUNDS;
			return w;
		end
		prod    = to_q26_sat(astar) * to_q26_sat(om);
		two_two = (prod + 64'h8000_0000) >> 32;
		w.omega_two_two = OMEGA_W'((two_two > OMEGA_TOP) ? OMEGA_TOP : two_two);
		w.status        = ST_OK;
		return w;
	endfunction

	function automatic void flag_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_CAP)
				$display("%0t: %s expected %0d got %0d", $time, name, want, got);
		end
	endfunction

	// compare one accepted result word with the oldest expectation
	task automatic check_word(input omega_word_t got);
		omega_word_t want;
		if (omega_expected.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_CAP)
				$display("%0t: result word with none expected, got %0d %0d %0d", $time,
					got.omega_one_one, got.omega_two_two, got.status);
			return;
		end
		want = omega_expected.pop_front();
		flag_field("omega_one_one", 32'(want.omega_one_one), 32'(got.omega_one_one));
		flag_field("omega_two_two", 32'(want.omega_two_two), 32'(got.omega_two_two));
		flag_field("status", 32'(want.status), 32'(got.status));
	endtask

	// offer one word after a gap and hold it until accepted
	task automatic drive_word(input logic [TEMP_W-1:0] temp, input logic [EPS_W-1:0] eps,
			input omega_word_t want, input int gap);
		if (gap > 0) begin
			sample_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_if.valid       <= 1'b1;
		sample_if.temperature <= temp;
		sample_if.well_depth  <= eps;
		@(posedge clk);
		while (!sample_if.ready) @(posedge clk);
		omega_expected.push_back(want);
	endtask

	// drop valid and wait until every expected word has come back
	task automatic park_and_drain();
		sample_if.valid <= 1'b0;
		do @(posedge clk); while (omega_expected.size() != 0);
	endtask

	task automatic run_random(input int count, input bit sender_idle);
		logic [TEMP_W-1:0] temp;
		logic [EPS_W-1:0]  eps;
		longint unsigned   tq;
		repeat (count) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					temp = TEMP_W'($urandom);
					eps  = EPS_W'($urandom);
				end
				3, 4, 5, 6, 7: begin
					// aim at a reduced temperature spread over all segments and the clamp
					eps  = EPS_W'($urandom_range(1, 131071));
					tq   = $urandom_range(0, 7864320);
					temp = TEMP_W'((tq * 64'(eps)) / 64'd409600);
				end
				8: begin
					temp = TEMP_W'($urandom);
					eps  = '0;
				end
				default: begin
					eps  = EPS_W'($urandom_range(1, 16));
					temp = TEMP_W'($urandom_range(0, 25600));
				end
			endcase
			drive_word(temp, eps, predict_omega(temp, eps),
				sender_idle ? $urandom_range(0, WORD_GAP_MAX) : 0);
		end
	endtask

	// result side: random stall per word, or a long hold when asked
	initial begin
		int stall;
		result_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (result_hold > 0) begin
				stall = result_hold;
			end else begin
				stall = idle_on ? $urandom_range(0, WORD_GAP_MAX) : 0;
			end
			result_hold = 0;
			if (stall > 0) begin
				result_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_if.ready <= 1'b1;
			@(posedge clk);
			while (!result_if.valid) @(posedge clk);
			check_word('{result_if.omega_one_one, result_if.omega_two_two, result_if.status});
		end
	end

	// watchdog on cycles with no word moving on either channel
	initial begin
		int idle;
		idle = 0;
		wait (arst_n === 1'b1);
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready)) begin
				idle = 0;
			end else begin
				idle++;
			end
		end
		$display("*** FAILED ***");
		$finish;
	end

	// stimulus
	initial begin
		probe_row_t probe_table [20];
		sample_if.valid       = 1'b0;
		sample_if.temperature = '0;
		sample_if.well_depth  = '0;

		// fit coefficients in Q32, lowest order first
		om_coef[SEG_LOW][0]     = scaled_coef(23527333, 7, 0, SEG_LOW);
		om_coef[SEG_LOW][1]     = scaled_coef(-13589968, 7, 1, SEG_LOW);
		om_coef[SEG_LOW][2]     = scaled_coef(52202460, 8, 2, SEG_LOW);
		om_coef[SEG_LOW][3]     = scaled_coef(-94262883, 9, 3, SEG_LOW);
		om_coef[SEG_LOW][4]     = scaled_coef(64354629, 10, 4, SEG_LOW);
		om_coef[SEG_MID][0]     = scaled_coef(12660308, 7, 0, SEG_MID);
		om_coef[SEG_MID][1]     = scaled_coef(-16441443, 8, 1, SEG_MID);
		om_coef[SEG_MID][2]     = scaled_coef(22945928, 9, 2, SEG_MID);
		om_coef[SEG_MID][3]     = scaled_coef(-16324168, 10, 3, SEG_MID);
		om_coef[SEG_MID][4]     = scaled_coef(45833672, 12, 4, SEG_MID);
		om_coef[SEG_HIGH][0]    = scaled_coef(85263337, 8, 0, SEG_HIGH);
		om_coef[SEG_HIGH][1]    = scaled_coef(-13552911, 9, 1, SEG_HIGH);
		om_coef[SEG_HIGH][2]    = scaled_coef(26162080, 11, 2, SEG_HIGH);
		om_coef[SEG_HIGH][3]    = scaled_coef(-24647654, 13, 3, SEG_HIGH);
		om_coef[SEG_HIGH][4]    = scaled_coef(86538568, 16, 4, SEG_HIGH);
		astar_coef[SEG_LOW][0]  = scaled_coef(11077725, 7, 0, SEG_LOW);
		astar_coef[SEG_LOW][1]  = scaled_coef(-94802344, 10, 1, SEG_LOW);
		astar_coef[SEG_LOW][2]  = scaled_coef(16918277, 10, 2, SEG_LOW);
		astar_coef[SEG_MID][0]  = scaled_coef(10871429, 7, 0, SEG_MID);
		astar_coef[SEG_MID][1]  = scaled_coef(31964282, 10, 1, SEG_MID);
		astar_coef[SEG_MID][2]  = scaled_coef(-89285689, 12, 2, SEG_MID);
		astar_coef[SEG_HIGH][0] = scaled_coef(11059000, 7, 0, SEG_HIGH);
		astar_coef[SEG_HIGH][1] = scaled_coef(65136364, 11, 1, SEG_HIGH);
		astar_coef[SEG_HIGH][2] = scaled_coef(-34090910, 13, 2, SEG_HIGH);

		// directed words; zero well depth rows carry their result, the rest use the model
		probe_table = '{
			'{24'd0,       17'd0,       1'b1, '{22'd0, 22'd0, ST_ZERO_EPS}},
			'{24'hFFFFFF,  17'd0,       1'b1, '{22'd0, 22'd0, ST_ZERO_EPS}},
			'{24'h5A5A5A,  17'd0,       1'b1, '{22'd0, 22'd0, ST_ZERO_EPS}},
			'{24'd0,       17'd1,       1'b0, '0},  // t of zero
			'{24'd0,       17'h1FFFF,   1'b0, '0},
			'{24'hFFFFFF,  17'd1,       1'b0, '0},  // far above the clamp
			'{24'hFFFFFF,  17'h1FFFF,   1'b0, '0},
			'{24'd1,       17'h1FFFF,   1'b0, '0},  // smallest nonzero t
			'{24'd79,      17'd100,     1'b0, '0},  // just under the first boundary
			'{24'd80,      17'd100,     1'b0, '0},  // t of exactly 5
			'{24'd159,     17'd100,     1'b0, '0},
			'{24'd160,     17'd100,     1'b0, '0},  // t of exactly 10
			'{24'd1599,    17'd100,     1'b0, '0},
			'{24'd1600,    17'd100,     1'b0, '0},  // t of exactly 100
			'{24'd1601,    17'd100,     1'b0, '0},  // just over the clamp
			'{24'd2,       17'd65536,   1'b0, '0},  // quotient on a half
			'{24'd1,       17'd1,       1'b0, '0},
			'{24'hAAAAAA,  17'h15555,   1'b0, '0},
			'{24'h555555,  17'h0AAAA,   1'b0, '0},
			'{24'h800000,  17'h10000,   1'b0, '0}
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (probe_table[i]) begin
			drive_word(probe_table[i].temperature, probe_table[i].well_depth,
				probe_table[i].typed ? probe_table[i].want :
				predict_omega(probe_table[i].temperature, probe_table[i].well_depth),
				$urandom_range(0, WORD_GAP_MAX));
		end

		// random words with idling on both sides
		run_random(500, 1'b1);

		// back to back on both sides
		idle_on = 1'b0;
		run_random(200, 1'b0);
		idle_on = 1'b1;
		park_and_drain();

		// long hold on the result side while words keep coming, so the pipe backs up
		result_hold = LONG_HOLD;
		run_random(200, 1'b0);
		park_and_drain();

		run_random(400, 1'b1);
		park_and_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// File: collision_integral_evaluator_core.f
design/cie_pkg.sv
design/cie_if.sv
design/collision_integral_evaluator_core.sv
design/cie_checker.sv
dv/tb_top.sv
